[rtl/ecv_pkg.sv]
package ecv_pkg;

	// one input item
	typedef struct packed {
		logic       cmd;
		logic [3:0] enc_sample;
		logic [7:0] mode;
	} item_t;

	// one result item
	typedef struct packed {
		logic [3:0] clock_hours;
		logic [5:0] clock_minutes;
		logic       clock_pm;
		logic [3:0] alarm_hour_value;
		logic [5:0] alarm_minute_value;
		logic       alarm_pm_flag;
		logic [3:0] volume_level;
		logic [1:0] time_turn;
		logic [1:0] volume_turn;
	} result_t;

	// item commands
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// encoder step codes
	localparam logic [1:0] TURN_NONE = 2'd0;
	localparam logic [1:0] TURN_CCW  = 2'd1;
	localparam logic [1:0] TURN_CW   = 2'd2;

	// field select codes
	localparam logic [7:0] MODE_CLK_MIN = 8'h01;
	localparam logic [7:0] MODE_CLK_HR  = 8'h02;
	localparam logic [7:0] MODE_ALM_MIN = 8'h05;
	localparam logic [7:0] MODE_ALM_HR  = 8'h06;

	// limits
	localparam logic [5:0] SEC_WRAP  = 6'd60;
	localparam logic [5:0] MIN_WRAP  = 6'd60;
	localparam logic [5:0] MIN_LAST  = 6'd59;
	localparam logic [3:0] HR_WRAP   = 4'd13;
	localparam logic [3:0] HR_LAST   = 4'd12;
	localparam logic [3:0] HR_FIRST  = 4'd1;
	localparam logic [3:0] VOL_MAX   = 4'h F;
	localparam logic [3:0] VOL_MIN   = 4'h4;
	localparam logic [3:0] VOL_RESET = 4'h7;
	localparam logic signed [3:0] EDGE_STEP = 4'sd4;

	// count change indexed by {previous phases, current phases}
	localparam logic signed [1:0] GRAY_DELTA [16] = '{
		2'sd0,  -2'sd1, 2'sd1,  2'sd0,
		2'sd1,  2'sd0,  2'sd0,  -2'sd1,
		-2'sd1, 2'sd0,  2'sd0,  2'sd1,
		2'sd0,  2'sd1,  -2'sd1, 2'sd0
	};

endpackage

[rtl/ecv_stream_if.sv]
interface ecv_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/encoder_clock_and_volume_control_top.sv]
// Twelve-hour clock with alarm time and volume, set by two quadrature encoders.
// Channels: item (sink) carries cmd, enc_sample and mode; result (source)
// carries the clock, alarm and volume state after each item plus the step
// code fired by each encoder on that item. Every item gives one result.
// The result of an item is registered: it is valid in the cycle after the item
// is accepted. Throughput: one item per cycle while the receiver takes each
// result, set by the single result register that holds the state-update output.
// The item channel stays ready while the result register is empty or is
// being taken in the same cycle; when the receiver stalls with a result
// waiting, item.ready drops and the result holds steady until transferred.
// Reset (arst_n low) clears the result valid flag and loads 12:00:00 am for
// the clock, 12:00 am for the alarm, volume 7 and idle encoder history.
// A tick raises the seconds with carry into minutes and hours; pm toggles
// on the 12 to 1 hour step. An encoder step fires at four valid Gray
// transitions in one direction; encoder one sets the field chosen by mode,
// encoder two moves the volume within 4 to 15.
module encoder_clock_and_volume_control_top (
	input  logic         clk,
	input  logic         arst_n,
	ecv_stream_if.sink   item,
	ecv_stream_if.source result
);
	import ecv_pkg::*;

	// architectural state
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [3:0]        hr_q;
	logic              pm_q;
	logic [5:0]        alm_min_q;
	logic [3:0]        alm_hr_q;
	logic              alm_pm_q;
	logic [3:0]        vol_q;
	logic [1:0]        enc1_prev_q;
	logic [1:0]        enc2_prev_q;
	logic signed [3:0] enc1_edges_q;
	logic signed [3:0] enc2_edges_q;

	// result register
	logic    res_v_q;
	result_t res_q;

	// next values
	logic [5:0]        sec_d;
	logic [5:0]        min_d;
	logic [3:0]        hr_d;
	logic              pm_d;
	logic [5:0]        alm_min_d;
	logic [3:0]        alm_hr_d;
	logic              alm_pm_d;
	logic [3:0]        vol_d;
	logic signed [3:0] enc1_edges_d;
	logic signed [3:0] enc2_edges_d;
	logic signed [3:0] enc1_sum;
	logic signed [3:0] enc2_sum;
	logic [1:0]        turn1;
	logic [1:0]        turn2;
	logic              up1;
	logic [5:0]        min_stepped;
	logic [5:0]        alm_min_stepped;
	logic [3:0]        hr_stepped;
	logic [3:0]        alm_hr_stepped;
	logic              accept;

	assign accept     = item.valid && item.ready;
	assign item.ready = !res_v_q || result.ready;

	// encoder edge counting
	always_comb begin
		enc1_sum = enc1_edges_q +
			4'(GRAY_DELTA[{enc1_prev_q, item.data.enc_sample[1:0]}]);
		enc2_sum = enc2_edges_q +
			4'(GRAY_DELTA[{enc2_prev_q, item.data.enc_sample[3:2]}]);
		turn1 = TURN_NONE;
		turn2 = TURN_NONE;
		enc1_edges_d = enc1_sum;
		enc2_edges_d = enc2_sum;
		if (enc1_sum == EDGE_STEP) begin
			turn1 = TURN_CCW;
			enc1_edges_d = '0;
		end else if (enc1_sum == -EDGE_STEP) begin
			turn1 = TURN_CW;
			enc1_edges_d = '0;
		end
		if (enc2_sum == EDGE_STEP) begin
			turn2 = TURN_CCW;
			enc2_edges_d = '0;
		end else if (enc2_sum == -EDGE_STEP) begin
			turn2 = TURN_CW;
			enc2_edges_d = '0;
		end
	end

	// wrapped minute and hour steps
	always_comb begin
		up1 = (turn1 == TURN_CCW);
		if (up1) begin
			min_stepped     = (min_q >= MIN_LAST) ? '0 : min_q + 6'd1;
			alm_min_stepped = (alm_min_q >= MIN_LAST) ? '0 : alm_min_q + 6'd1;
			hr_stepped      = (hr_q >= HR_LAST) ? HR_FIRST : hr_q + 4'd1;
			alm_hr_stepped  = (alm_hr_q >= HR_LAST) ? HR_FIRST : alm_hr_q + 4'd1;
		end else begin
			min_stepped     = (min_q == '0) ? MIN_LAST : min_q - 6'd1;
			alm_min_stepped = (alm_min_q == '0) ? MIN_LAST : alm_min_q - 6'd1;
			hr_stepped      = (hr_q <= HR_FIRST) ? HR_LAST : hr_q - 4'd1;
			alm_hr_stepped  = (alm_hr_q <= HR_FIRST) ? HR_LAST : alm_hr_q - 4'd1;
		end
	end

	// next state for one item
	always_comb begin
		sec_d     = sec_q;
		min_d     = min_q;
		hr_d      = hr_q;
		pm_d      = pm_q;
		alm_min_d = alm_min_q;
		alm_hr_d  = alm_hr_q;
		alm_pm_d  = alm_pm_q;
		vol_d     = vol_q;
		if (item.data.cmd == CMD_TICK) begin
			sec_d = sec_q + 6'd1;
			if (sec_d >= SEC_WRAP) begin
				sec_d = '0;
				min_d = min_q + 6'd1;
			end
			if (min_d >= MIN_WRAP) begin
				min_d = '0;
				hr_d  = hr_q + 4'd1;
			end
			if (hr_d >= HR_WRAP) begin
				hr_d = HR_FIRST;
				pm_d = !pm_q;
			end
		end else begin
			if (turn1 != TURN_NONE) begin
				unique case (item.data.mode)
					MODE_CLK_MIN: min_d = min_stepped;
					MODE_CLK_HR: begin
						hr_d = hr_stepped;
						if ((up1 && hr_q >= HR_LAST) || (!up1 && hr_q <= HR_FIRST))
							pm_d = !pm_q;
					end
					MODE_ALM_MIN: alm_min_d = alm_min_stepped;
					MODE_ALM_HR: begin
						alm_hr_d = alm_hr_stepped;
						if ((up1 && alm_hr_q >= HR_LAST) || (!up1 && alm_hr_q <= HR_FIRST))
							alm_pm_d = !alm_pm_q;
					end
					default: ;
				endcase
			end
			if (turn2 == TURN_CCW && vol_q < VOL_MAX)
				vol_d = vol_q + 4'd1;
			else if (turn2 == TURN_CW && vol_q > VOL_MIN)
				vol_d = vol_q - 4'd1;
		end
	end

	// state update on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q        <= '0;
			min_q        <= '0;
			hr_q         <= HR_LAST;
			pm_q         <= 1'b0;
			alm_min_q    <= '0;
			alm_hr_q     <= HR_LAST;
			alm_pm_q     <= 1'b0;
			vol_q        <= VOL_RESET;
			enc1_prev_q  <= '0;
			enc2_prev_q  <= '0;
			enc1_edges_q <= '0;
			enc2_edges_q <= '0;
		end else if (accept) begin
			sec_q     <= sec_d;
			min_q     <= min_d;
			hr_q      <= hr_d;
			pm_q      <= pm_d;
			alm_min_q <= alm_min_d;
			alm_hr_q  <= alm_hr_d;
			alm_pm_q  <= alm_pm_d;
			vol_q     <= vol_d;
			if (item.data.cmd == CMD_SAMPLE) begin
				enc1_prev_q  <= item.data.enc_sample[1:0];
				enc2_prev_q  <= item.data.enc_sample[3:2];
				enc1_edges_q <= enc1_edges_d;
				enc2_edges_q <= enc2_edges_d;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (item.ready) begin
			res_v_q <= item.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.clock_hours        <= hr_d;
			res_q.clock_minutes      <= min_d;
			res_q.clock_pm           <= pm_d;
			res_q.alarm_hour_value   <= alm_hr_d;
			res_q.alarm_minute_value <= alm_min_d;
			res_q.alarm_pm_flag      <= alm_pm_d;
			res_q.volume_level       <= vol_d;
			res_q.time_turn          <= (item.data.cmd == CMD_SAMPLE) ? turn1 : TURN_NONE;
			res_q.volume_turn        <= (item.data.cmd == CMD_SAMPLE) ? turn2 : TURN_NONE;
		end
	end

	assign result.valid = res_v_q;
	assign result.data  = res_q;

endmodule

[rtl/ecv_checker.sv]
module ecv_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            in_cmd,
	input logic            out_valid,
	input logic            out_ready,
	input ecv_pkg::result_t out_data
);
	import ecv_pkg::*;

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// every transfer in gives a result next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after item transfer");

	// input backpressure only while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("item channel stalled without cause");

	// a tick fires no encoder step
	a_tick_turn: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CMD_TICK |=>
		out_data.time_turn == TURN_NONE && out_data.volume_turn == TURN_NONE)
		else $error("step reported on tick");

	// reported clock hours, clock minutes and volume in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.clock_hours >= HR_FIRST && out_data.clock_hours <= HR_LAST
		&& out_data.volume_level >= VOL_MIN && out_data.clock_minutes <= MIN_LAST)
		else $error("result field out of range");

endmodule

bind encoder_clock_and_volume_control_top ecv_checker u_ecv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_cmd    (item.data.cmd),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
